/* hw/rtl/sector_health_tracker_defines.svh */
// Assertion macros for the sector health tracker.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef SECTOR_HEALTH_TRACKER_DEFINES_SVH
`define SECTOR_HEALTH_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SHT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sht_pkg.sv */
// Shared types, constants and helpers for the sector health tracker.
// No dependencies.
package sht_pkg;

    localparam int SECTORS   = 1024;
    localparam int SECT_W    = $clog2(SECTORS);
    localparam int ERR_W     = 16;
    localparam int SCORE_W   = 10;
    localparam int CNT32_W   = 32;
    localparam int TICK_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [SCORE_W:0] PERFECT       = 11'd1000;
    localparam logic [SCORE_W:0] STALE_PENALTY = 11'd50;
    localparam logic [SCORE_W:0] TREND_MARGIN  = 11'd50;

    // error sum times 1000 fits in this many bits
    localparam int DIVD_W    = ERR_W + 1 + SCORE_W;
    localparam int DIV_CNT_W = $clog2(DIVD_W);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WARN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DANGER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE    = 2'd2;

    localparam logic [SCORE_W-1:0] WARN_RESET   = 10'd700;
    localparam logic [SCORE_W-1:0] DANGER_RESET = 10'd300;
    localparam logic [TICK_W-1:0]  AGE_RESET    = 32'd3600000;

    typedef enum logic [0:0] {OP_ACCESS, OP_SCAN} t_op;
    typedef enum logic [1:0] {RISK_SAFE, RISK_CAUTION, RISK_DANGER} t_risk;
    typedef enum logic [1:0] {TREND_STABLE, TREND_UP, TREND_DOWN} t_trend;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_MUL, S_DIV, S_WRITE, S_OUT
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [SECT_W-1:0] sector;
        logic              read_ok;
        logic              write_ok;
        logic [TICK_W-1:0] now;
    } t_cmd;

    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] score;
        logic [ERR_W-1:0]   read_errs;
        logic [ERR_W-1:0]   write_errs;
        logic [CNT32_W-1:0] accesses;
        logic [TICK_W-1:0]  scan_tick;
        t_trend             trend;
        t_risk              risk;
    } t_rec;

    typedef struct packed {
        logic               start;
        logic [DIVD_W-1:0]  dividend;
        logic [CNT32_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [ERR_W-1:0] sat_inc_err(input logic [ERR_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT32_W-1:0] sat_inc32(input logic [CNT32_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT32_W-1:0] sat_dec32(input logic [CNT32_W-1:0] v);
        return (v == '0) ? v : v - 1'b1;
    endfunction

endpackage

/* hw/rtl/sector_health_tracker.sv */
// Sector health tracker: an input item updates one sector's health record,
// unless it is a scan of an absent sector, which is skipped, and yields one
// result item. Input and output channels use valid/ready; a transfer happens
// when both are high. Items enter a two-deep command queue, so the input side
// keeps taking items while a result waits, until the queue is full. Each item
// that is not skipped does a read-modify-write of its record in the 1024-entry
// table; on a present sector it runs the error rate through a divider of 27
// iterations, and a scan of a present sector makes two divider passes. Items
// are processed one at a time: the next item starts the cycle after a result
// loads.
// After reset the record table is cleared one entry a cycle, all 1024 entries;
// items queue up meanwhile but are not processed. Write configuration via
// i_cfg_we/i_cfg_idx/i_cfg_data only while no item is in flight.
// If the receiver stalls, the result holds in the output register and the
// next item stops before it would load that register.
// Depends on sht_pkg, sht_front, sht_div, sht_back and the defines header.
`include "sector_health_tracker_defines.svh"
module sector_health_tracker import sht_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_mode,
    input  logic [SECT_W-1:0]    i_sector,
    input  logic                 i_read_ok,
    input  logic                 i_write_ok,
    input  logic [TICK_W-1:0]    i_now,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [SCORE_W-1:0]   o_score,
    output logic [1:0]           o_risk,
    output logic [1:0]           o_trend,
    output logic                 o_record_created,
    output logic                 o_skipped,
    output logic [CNT32_W-1:0]   o_warnings_total,
    output logic [CNT32_W-1:0]   o_active_warning_count,
    output logic [CNT32_W-1:0]   o_high_risk_count
);

    logic     w_cmd_valid;
    t_cmd     w_cmd;
    logic     w_cmd_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    sht_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_sector    (i_sector),
        .i_read_ok   (i_read_ok),
        .i_write_ok  (i_write_ok),
        .i_now       (i_now),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    sht_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    sht_back u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_idx              (i_cfg_idx),
        .i_cfg_data             (i_cfg_data),
        .i_cmd_valid            (w_cmd_valid),
        .i_cmd                  (w_cmd),
        .o_cmd_pop              (w_cmd_pop),
        .o_div_req              (w_div_req),
        .i_div_rsp              (w_div_rsp),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_score                (o_score),
        .o_risk                 (o_risk),
        .o_trend                (o_trend),
        .o_record_created       (o_record_created),
        .o_skipped              (o_skipped),
        .o_warnings_total       (o_warnings_total),
        .o_active_warning_count (o_active_warning_count),
        .o_high_risk_count      (o_high_risk_count)
    );

    `SHT_ASSERT_IMPL(a_score_range, o_valid, o_score <= SCORE_W'(PERFECT),
        "score above perfect")
    `SHT_ASSERT_IMPL(a_skip_blank, o_valid && o_skipped,
        !o_record_created && o_score == '0, "skipped result not blank")
    `SHT_ASSERT_IMPL(a_create_perfect, o_valid && o_record_created,
        o_score == SCORE_W'(PERFECT) && o_risk == RISK_SAFE, "new record not perfect")
    `SHT_ASSERT_NEXT(a_warn_mono, 1'b1, o_warnings_total >= $past(o_warnings_total),
        "warning total went down")

endmodule

/* hw/rtl/sht_front.sv */
// Front end: accepts items, classifies them into commands and queues them.
// Depends on sht_pkg.
module sht_front import sht_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic [SECT_W-1:0] i_sector,
    input  logic              i_read_ok,
    input  logic              i_write_ok,
    input  logic [TICK_W-1:0] i_now,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_pop
);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;
    t_cmd              w_new;
    logic              w_push;

    assign o_ready     = (r_count != QCNT_W'(QDEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rptr];

    always_comb begin
        w_new.op       = i_mode ? OP_SCAN : OP_ACCESS;
        w_new.sector   = i_sector;
        w_new.read_ok  = i_read_ok;
        w_new.write_ok = i_write_ok;
        w_new.now      = i_now;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({w_push, i_cmd_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/sht_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on sht_pkg.
module sht_div import sht_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIVD_W-1:0]    r_q;
    logic [CNT32_W-1:0]   r_rem;
    logic [CNT32_W-1:0]   r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [CNT32_W:0]     w_trial;
    logic                 w_fit;

    assign w_trial = {r_rem, r_q[DIVD_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_cnt <= DIV_CNT_W'(DIVD_W - 1);
        end else if (r_busy) begin
            r_rem <= w_fit ? CNT32_W'(w_trial - {1'b0, r_div}) : w_trial[CNT32_W-1:0];
            r_q   <= {r_q[DIVD_W-2:0], w_fit};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/sht_back.sv */
// Back end: record table, score sequencer, global counters, output register.
// Depends on sht_pkg; drives the request side of sht_div.
module sht_back import sht_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_cmd_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_cmd_pop,
    output t_div_req             o_div_req,
    input  t_div_rsp             i_div_rsp,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [SCORE_W-1:0]   o_score,
    output logic [1:0]           o_risk,
    output logic [1:0]           o_trend,
    output logic                 o_record_created,
    output logic                 o_skipped,
    output logic [CNT32_W-1:0]   o_warnings_total,
    output logic [CNT32_W-1:0]   o_active_warning_count,
    output logic [CNT32_W-1:0]   o_high_risk_count
);

    t_state r_state, n_state;

    t_rec               r_mem [SECTORS];
    t_rec               r_rd_data;
    logic [SECT_W-1:0]  r_clr_addr;
    t_cmd               r_cmd;
    t_rec               r_rec;
    t_rec               n_read_rec;
    logic [SCORE_W-1:0] r_prev_score;
    t_risk              r_prev_risk;
    logic               r_final;
    logic               r_upd;
    logic               r_created;
    logic               r_skipped;
    logic               r_stale;

    logic [SCORE_W-1:0] r_warn_th, r_danger_th;
    logic [TICK_W-1:0]  r_age;
    logic [CNT32_W-1:0] r_warn_total, r_active_warn, r_high_risk;

    logic               w_mem_we;
    logic [SECT_W-1:0]  w_waddr;
    t_rec               w_wdata;
    logic               w_out_load;
    logic [ERR_W:0]     w_errsum;
    logic [TICK_W-1:0]  w_age_diff;
    logic [SCORE_W:0]   w_base, w_score;
    t_trend             w_trend;
    t_risk              w_risk;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_addr == SECT_W'(SECTORS - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_cmd_valid) n_state = S_READ;
            S_READ: begin
                if (r_rd_data.valid) begin
                    n_state = S_MUL;
                end else if (r_cmd.op == OP_ACCESS) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MUL:   n_state = S_DIV;
            S_DIV:   if (i_div_rsp.done) n_state = r_final ? S_WRITE : S_MUL;
            S_WRITE: n_state = S_OUT;
            S_OUT:   if (!o_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        o_cmd_pop  = 1'b0;
        w_mem_we   = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_CLEAR: w_mem_we   = 1'b1;
            S_IDLE:  o_cmd_pop  = i_cmd_valid;
            S_WRITE: w_mem_we   = 1'b1;
            S_OUT:   w_out_load = !o_valid || i_ready;
            default: ;
        endcase
    end

    assign w_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_cmd.sector;
    assign w_wdata = (r_state == S_CLEAR) ? t_rec'('0) : r_rec;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[i_cmd.sector];
    end

    // record after the first update of this item
    always_comb begin
        n_read_rec = r_rd_data;
        if (!r_rd_data.valid) begin
            n_read_rec.valid      = 1'b1;
            n_read_rec.score      = PERFECT[SCORE_W-1:0];
            n_read_rec.read_errs  = '0;
            n_read_rec.write_errs = '0;
            n_read_rec.accesses   = CNT32_W'(1);
            n_read_rec.scan_tick  = r_cmd.now;
            n_read_rec.trend      = TREND_STABLE;
            n_read_rec.risk       = RISK_SAFE;
        end else if (r_cmd.op == OP_ACCESS) begin
            if (!r_cmd.read_ok) n_read_rec.read_errs = sat_inc_err(r_rd_data.read_errs);
            if (!r_cmd.write_ok) n_read_rec.write_errs = sat_inc_err(r_rd_data.write_errs);
            n_read_rec.accesses = sat_inc32(r_rd_data.accesses);
        end else begin
            n_read_rec.scan_tick = r_cmd.now;
            if (!r_cmd.read_ok) n_read_rec.read_errs = sat_inc_err(r_rd_data.read_errs);
        end
    end

    assign w_errsum   = {1'b0, r_rec.read_errs} + {1'b0, r_rec.write_errs};
    assign w_age_diff = r_cmd.now - r_rec.scan_tick - r_age;

    assign o_div_req.start    = (r_state == S_MUL);
    assign o_div_req.dividend = DIVD_W'(w_errsum) * DIVD_W'(PERFECT);
    assign o_div_req.divisor  = r_rec.accesses;

    // score from the error rate, then the stale-scan penalty
    always_comb begin
        if (r_rec.accesses == '0) begin
            w_base = PERFECT;
        end else if (i_div_rsp.quotient >= DIVD_W'(PERFECT)) begin
            w_base = '0;
        end else begin
            w_base = PERFECT - i_div_rsp.quotient[SCORE_W:0];
        end
        if (!r_stale) begin
            w_score = w_base;
        end else if (w_base > STALE_PENALTY) begin
            w_score = w_base - STALE_PENALTY;
        end else begin
            w_score = '0;
        end
    end

    always_comb begin
        if (w_score > {1'b0, r_prev_score} + TREND_MARGIN) begin
            w_trend = TREND_UP;
        end else if (w_score + TREND_MARGIN < {1'b0, r_prev_score}) begin
            w_trend = TREND_DOWN;
        end else begin
            w_trend = TREND_STABLE;
        end
        if (w_score >= {1'b0, r_warn_th}) begin
            w_risk = RISK_SAFE;
        end else if (w_score >= {1'b0, r_danger_th}) begin
            w_risk = RISK_CAUTION;
        end else begin
            w_risk = RISK_DANGER;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd <= i_cmd;
            end
            S_READ: begin
                r_rec        <= n_read_rec;
                r_prev_score <= r_rd_data.score;
                r_prev_risk  <= r_rd_data.risk;
                r_final      <= (r_cmd.op == OP_ACCESS);
                r_upd        <= r_rd_data.valid;
                r_created    <= !r_rd_data.valid && (r_cmd.op == OP_ACCESS);
                r_skipped    <= !r_rd_data.valid && (r_cmd.op == OP_SCAN);
            end
            S_MUL: begin
                r_stale <= (r_rec.scan_tick != '0) && (w_age_diff != '0)
                           && !w_age_diff[TICK_W-1];
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    r_rec.score <= w_score[SCORE_W-1:0];
                    if (!r_final) begin
                        // scan: intermediate score, then the access update
                        r_prev_score <= w_score[SCORE_W-1:0];
                        if (!r_cmd.read_ok) r_rec.read_errs <= sat_inc_err(r_rec.read_errs);
                        r_rec.accesses <= sat_inc32(r_rec.accesses);
                        r_final        <= 1'b1;
                    end else begin
                        r_rec.trend <= w_trend;
                        r_rec.risk  <= w_risk;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_warn_th     <= WARN_RESET;
            r_danger_th   <= DANGER_RESET;
            r_age         <= AGE_RESET;
            r_warn_total  <= '0;
            r_active_warn <= '0;
            r_high_risk   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WARN:   r_warn_th   <= i_cfg_data[SCORE_W-1:0];
                    CFG_DANGER: r_danger_th <= i_cfg_data[SCORE_W-1:0];
                    CFG_AGE:    r_age       <= i_cfg_data[TICK_W-1:0];
                    default:    ;
                endcase
            end
            if (r_state == S_WRITE && r_upd) begin
                if (r_rec.risk > r_prev_risk) begin
                    r_warn_total  <= sat_inc32(r_warn_total);
                    r_active_warn <= sat_inc32(r_active_warn);
                    if (r_rec.risk == RISK_DANGER) r_high_risk <= sat_inc32(r_high_risk);
                end else if (r_rec.risk < r_prev_risk) begin
                    if (r_rec.risk == RISK_SAFE) r_active_warn <= sat_dec32(r_active_warn);
                    if (r_prev_risk == RISK_DANGER) r_high_risk <= sat_dec32(r_high_risk);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid                <= 1'b0;
            o_score                <= '0;
            o_risk                 <= '0;
            o_trend                <= '0;
            o_record_created       <= 1'b0;
            o_skipped              <= 1'b0;
            o_warnings_total       <= '0;
            o_active_warning_count <= '0;
            o_high_risk_count      <= '0;
        end else if (w_out_load) begin
            o_valid                <= 1'b1;
            o_score                <= r_skipped ? '0 : r_rec.score;
            o_risk                 <= r_skipped ? RISK_SAFE : r_rec.risk;
            o_trend                <= r_skipped ? TREND_STABLE : r_rec.trend;
            o_record_created       <= r_created;
            o_skipped              <= r_skipped;
            o_warnings_total       <= r_warn_total;
            o_active_warning_count <= r_active_warn;
            o_high_risk_count      <= r_high_risk;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

endmodule
